>>> rtl/sse_pkg.sv
// shared types and constants of the segmented stack engine
package sse_pkg;

  localparam int NUM_STACKS = 8;
  localparam int MAX_DEPTH  = 16;
  localparam int DATA_W     = 32;

  localparam int CAP_W      = 5;
  localparam int CAP_RESET  = 5;
  localparam int IDX_W      = 3;
  localparam int CMD_W      = 2;
  localparam int STS_W      = 2;

  localparam int SW         = $clog2(NUM_STACKS);
  localparam int FW         = $clog2(MAX_DEPTH + 1);
  localparam int MEM_DEPTH  = NUM_STACKS * MAX_DEPTH;
  localparam int ADDR_W     = $clog2(MEM_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH   = 2'd0,
    CMD_POP    = 2'd1,
    CMD_POP_AT = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_e;

  typedef enum logic [STS_W-1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADIDX = 2'd3
  } status_e;

  typedef struct packed {
    logic capture;
    logic exec;
    logic load;
  } sse_cmd_t;

endpackage

>>> rtl/sse_ctrl.sv
// sequencer: accept, execute against the store, load the result register
module sse_ctrl import sse_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output sse_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  always_comb begin
    out_free    = !out_valid_q || out_ready_i;
    in_ready_o  = (state_q == S_IDLE) || ((state_q == S_RESP) && out_free);
    cmd_o.capture = in_valid_i && in_ready_o;
    cmd_o.exec    = (state_q == S_EXEC);
    cmd_o.load    = (state_q == S_RESP) && out_free;
    out_valid_o   = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (cmd_o.capture) state_q <= S_EXEC;
        end
        S_EXEC: begin
          state_q <= S_RESP;
        end
        S_RESP: begin
          if (cmd_o.load) state_q <= cmd_o.capture ? S_EXEC : S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
      if (cmd_o.load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/sse_dp.sv
// datapath: fill counts, current stack, item memory and result register
module sse_dp import sse_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  sse_cmd_t          cmd_i,
  input  logic [CMD_W-1:0]  command_i,
  input  logic [DATA_W-1:0] push_value_i,
  input  logic [IDX_W-1:0]  stack_index_i,
  input  logic              cfg_we_i,
  input  logic [CAP_W-1:0]  cfg_wdata_i,
  output logic [DATA_W-1:0] pop_value_o,
  output logic [STS_W-1:0]  status_o
);

  logic [CAP_W-1:0]  cap_q;
  logic [SW-1:0]     cur_q, cur_d;
  logic [FW-1:0]     fill_q [NUM_STACKS];

  logic [CMD_W-1:0]  cmd_q;
  logic [DATA_W-1:0] val_q;
  logic [IDX_W-1:0]  idx_q;

  logic [DATA_W-1:0] item_mem_q [MEM_DEPTH];
  logic [DATA_W-1:0] rdata_q;
  logic [STS_W-1:0]  st_q;
  logic              rd_q;
  logic [DATA_W-1:0] out_val_q;
  logic [STS_W-1:0]  out_st_q;

  logic [FW-1:0]         cap_eff;
  logic [NUM_STACKS-1:0] full_v, nz_v;
  logic                  found;
  logic [SW-1:0]         sel, tsel;
  logic [FW-1:0]         fsel, pos;
  logic                  op_wr, op_rd;
  status_e               st;
  logic [ADDR_W-1:0]     addr;

  always_comb begin
    if (cap_q == '0) begin
      cap_eff = FW'(1);
    end else if (int'(cap_q) > MAX_DEPTH) begin
      cap_eff = FW'(MAX_DEPTH);
    end else begin
      cap_eff = FW'(cap_q);
    end

    found = 1'b0;
    sel   = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      full_v[s] = (fill_q[s] >= cap_eff);
      nz_v[s]   = (fill_q[s] != '0);
      // ascending scan, the highest nonempty stack at or below current wins
      if ((SW'(s) <= cur_q) && nz_v[s]) begin
        found = 1'b1;
        sel   = SW'(s);
      end
    end

    op_wr = 1'b0;
    op_rd = 1'b0;
    tsel  = cur_q;
    cur_d = cur_q;
    st    = ST_OK;
    case (cmd_q)
      CMD_PUSH: begin
        if (full_v[cur_q]) begin
          if (cur_q == SW'(NUM_STACKS - 1)) begin
            st = ST_FULL;
          end else begin
            tsel  = cur_q + SW'(1);
            cur_d = tsel;
            if (full_v[tsel]) st = ST_FULL;
            else op_wr = 1'b1;
          end
        end else begin
          op_wr = 1'b1;
        end
      end
      CMD_POP: begin
        if (found) begin
          tsel  = sel;
          cur_d = sel;
          op_rd = 1'b1;
        end else begin
          cur_d = '0;
          st    = ST_EMPTY;
        end
      end
      CMD_POP_AT: begin
        if ((int'(idx_q) >= NUM_STACKS) || (int'(idx_q) > int'(cur_q)) ||
            !nz_v[SW'(idx_q)]) begin
          st = ST_BADIDX;
        end else begin
          tsel  = SW'(idx_q);
          op_rd = 1'b1;
        end
      end
      default: begin
      end
    endcase

    fsel = '0;
    for (int s = 0; s < NUM_STACKS; s++) begin
      if (SW'(s) == tsel) fsel = fill_q[s];
    end
    pos  = op_wr ? fsel : fsel - FW'(1);
    addr = ADDR_W'(int'(tsel) * MAX_DEPTH + int'(pos));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q <= CAP_W'(CAP_RESET);
      cur_q <= '0;
      st_q  <= ST_OK;
      rd_q  <= 1'b0;
      for (int s = 0; s < NUM_STACKS; s++) begin
        fill_q[s] <= '0;
      end
    end else begin
      if (cfg_we_i) cap_q <= cfg_wdata_i;
      if (cmd_i.exec) begin
        cur_q <= cur_d;
        st_q  <= st;
        rd_q  <= op_rd;
        for (int s = 0; s < NUM_STACKS; s++) begin
          if (SW'(s) == tsel) begin
            if (op_wr) fill_q[s] <= fsel + FW'(1);
            else if (op_rd) fill_q[s] <= fsel - FW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      cmd_q <= command_i;
      val_q <= push_value_i;
      idx_q <= stack_index_i;
    end
    if (cmd_i.exec && op_wr) item_mem_q[addr] <= val_q;
    if (cmd_i.exec && op_rd) rdata_q <= item_mem_q[addr];
    if (cmd_i.load) begin
      out_val_q <= rd_q ? rdata_q : '0;
      out_st_q  <= st_q;
    end
  end

  assign pop_value_o = out_val_q;
  assign status_o    = out_st_q;

endmodule

>>> rtl/segmented_stack_engine.sv
// top level of the segmented stack engine
//
//  channel  | direction | tdata / tuser contents (lowest bit first)
//  s_axis   | in        | tdata: push_value[31:0], stack_index[34:32], zero pad; tuser: command
//  m_axis   | out       | tdata: pop_value[31:0]; tuser: status
//  cfg      | in        | cfg_wdata_i: stack_capacity, written when cfg_we_i is high
//
// an item passes through an execute state, which updates the fill counts and accesses
// the item memory, and a response state, which moves the registered read data into the
// output register. a new item is accepted in the response state while the last result
// loads; the response state is set by the synchronous read port of the item memory.
// reset clears fill counts and current stack and sets capacity to 5; memory is not cleared.
// a stalled output holds its result; the next result waits behind it, input held off.
module segmented_stack_engine import sse_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // push_value, stack_index, zero pad
  input  logic [1:0]  s_axis_tuser,   // command
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // pop_value
  output logic [1:0]  m_axis_tuser,   // status
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i
);

  sse_cmd_t cmd;

  sse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .cmd_o       (cmd)
  );

  sse_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .command_i     (s_axis_tuser),
    .push_value_i  (s_axis_tdata[31:0]),
    .stack_index_i (s_axis_tdata[34:32]),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .pop_value_o   (m_axis_tdata),
    .status_o      (m_axis_tuser)
  );

  // an accepted beat occupies the execute stage for the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !s_axis_tready)
    else $error("input ready while executing");

  a_exec_not_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.exec && cmd.capture))
    else $error("accept during execute");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.load |=> m_axis_tvalid)
    else $error("result loaded but output not valid");

  a_exec_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> cmd.exec)
    else $error("accepted beat not executed");

endmodule
